// ----- rtl/core/sfr_pkg.sv -----
package sfr_pkg;

  localparam int RX_BUFFER_BYTES = 512;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  PRE_HI   = 8'h79;
  localparam logic [7:0]  PRE_LO   = 8'hFC;
  localparam logic [15:0] HUNT_SAT = 16'hFFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED       = 3'd0,
    CFG_TYPE_MASK  = 3'd1,
    CFG_ACK_TYPE   = 3'd2,
    CFG_NAK_TYPE   = 3'd3,
    CFG_ACK_LEN    = 3'd4,
    CFG_HDR_OVH    = 3'd5,
    CFG_MAX_LEN    = 3'd6,
    CFG_HUNT_LIMIT = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_HUNT1     = 4'd0,
    PH_HUNT2     = 4'd1,
    PH_FLEN_H    = 4'd2,
    PH_FLEN_L    = 4'd3,
    PH_TYPE      = 4'd4,
    PH_SHORT_ACK = 4'd5,
    PH_SEQ       = 4'd6,
    PH_ACK       = 4'd7,
    PH_TLEN_H    = 4'd8,
    PH_TLEN_L    = 4'd9,
    PH_TEXT      = 4'd10,
    PH_CRC_H     = 4'd11,
    PH_CRC_L     = 4'd12
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_TIMEOUT  = 4'd1,
    ST_SYNC     = 4'd2,
    ST_SHORT    = 4'd3,
    ST_FRAMELEN = 4'd4,
    ST_ACKLEN   = 4'd5,
    ST_TEXTLEN  = 4'd6,
    ST_OVERFLOW = 4'd7,
    ST_CRC      = 4'd8
  } status_t;

  typedef enum logic {
    KIND_TEXT   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  localparam logic [3:0] STG_PREAMBLE = 4'd1;
  localparam logic [3:0] STG_LENGTH   = 4'd2;
  localparam logic [3:0] STG_TYPE     = 4'd3;
  localparam logic [3:0] STG_SHORT    = 4'd4;
  localparam logic [3:0] STG_SEQ      = 4'd5;
  localparam logic [3:0] STG_ACK      = 4'd6;
  localparam logic [3:0] STG_TEXT     = 4'd7;
  localparam logic [3:0] STG_CRC      = 4'd8;

  typedef struct packed {
    logic [7:0]  seed;
    logic [7:0]  type_mask;
    logic [7:0]  ack_type;
    logic [7:0]  nak_type;
    logic [15:0] ack_len;
    logic [15:0] hdr_ovh;
    logic [15:0] max_len;
    logic [15:0] hunt_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] hunt;
    logic [15:0] crc;
    logic [15:0] flen;
    logic [7:0]  type_b;
    logic [7:0]  seq;
    logic [7:0]  ack;
    logic [15:0] tcnt;
    logic [15:0] tpos;
    logic        ovf;
    logic [7:0]  crc_hi;
    logic [3:0]  stage;
  } frame_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  text_byte;
    logic [15:0] text_index;
    status_t     status;
    logic [7:0]  frame_type;
    logic [7:0]  seq_num;
    logic [7:0]  ack_seq;
    logic [15:0] text_length;
    logic [3:0]  progress;
    logic [15:0] computed_crc;
  } out_item_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
      else       r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sfr_in_if.sv -----
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfr_out_if.sv -----
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  text_byte;
  logic [15:0] text_index;
  logic [3:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  seq_num;
  logic [7:0]  ack_seq;
  logic [15:0] text_length;
  logic [3:0]  progress;
  logic [15:0] computed_crc;

  modport source (output valid, output out_kind, output text_byte, output text_index,
                  output status, output frame_type, output seq_num, output ack_seq,
                  output text_length, output progress, output computed_crc, input ready);
  modport sink   (input valid, input out_kind, input text_byte, input text_index,
                  input status, input frame_type, input seq_num, input ack_seq,
                  input text_length, input progress, input computed_crc, output ready);
endinterface

// ----- rtl/core/sfr_cfg_if.sv -----
interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- rtl/core/sfr_cfg_regs.sv -----
module sfr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  sfr_cfg_if.sink       cfg_ch,
  output sfr_pkg::cfg_t cfg
);
  import sfr_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign cfg_ch.ready = 1'b1;
  assign wr  = cfg_ch.valid && cfg_ch.ready;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed       <= 8'd0;
      cfg_r.type_mask  <= 8'd63;
      cfg_r.ack_type   <= 8'd17;
      cfg_r.nak_type   <= 8'd18;
      cfg_r.ack_len    <= 16'd6;
      cfg_r.hdr_ovh    <= 16'd9;
      cfg_r.max_len    <= 16'd521;
      cfg_r.hunt_limit <= 16'd525;
    end else if (wr) begin
      case (cfg_idx_t'(cfg_ch.idx))
        CFG_SEED:       cfg_r.seed       <= cfg_ch.data[7:0];
        CFG_TYPE_MASK:  cfg_r.type_mask  <= cfg_ch.data[7:0];
        CFG_ACK_TYPE:   cfg_r.ack_type   <= cfg_ch.data[7:0];
        CFG_NAK_TYPE:   cfg_r.nak_type   <= cfg_ch.data[7:0];
        CFG_ACK_LEN:    cfg_r.ack_len    <= cfg_ch.data;
        CFG_HDR_OVH:    cfg_r.hdr_ovh    <= cfg_ch.data;
        CFG_MAX_LEN:    cfg_r.max_len    <= cfg_ch.data;
        CFG_HUNT_LIMIT: cfg_r.hunt_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sfr_parser.sv -----
module sfr_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  input  sfr_pkg::cfg_t      cfg,
  output logic               res_valid,
  output sfr_pkg::out_item_t res
);
  import sfr_pkg::*;

  frame_t      st_r;
  frame_t      st_nxt;
  frame_t      upd;
  logic        fin;
  logic        emit;
  status_t     fst;
  logic [15:0] crc_b;
  logic [7:0]  tmask;
  logic [16:0] tsum;
  logic [16:0] pos_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else        st_r <= st_nxt;
  end

  always_comb begin
    upd     = st_r;
    fin     = 1'b0;
    emit    = 1'b0;
    fst     = ST_OK;
    crc_b   = crc_step(st_r.crc, rx_byte);
    tmask   = rx_byte & cfg.type_mask;
    tsum    = {1'b0, st_r.tcnt[15:8], rx_byte} + {1'b0, cfg.hdr_ovh};
    pos_inc = {1'b0, st_r.tpos} + 17'd1;
    if (step) begin
      if (req_type) begin
        fin = 1'b1;
        fst = (st_r.phase inside {[PH_FLEN_H:PH_CRC_L]}) ? ST_SHORT : ST_TIMEOUT;
      end else begin
        case (st_r.phase)
          PH_HUNT2: begin
            if (rx_byte != PRE_LO) begin
              fin = 1'b1;
              fst = ST_SYNC;
            end else begin
              upd.stage = STG_PREAMBLE;
              upd.crc   = crc_step(16'h0000, cfg.seed);
              upd.phase = PH_FLEN_H;
            end
          end
          PH_FLEN_H: begin
            upd.crc   = crc_b;
            upd.flen  = {rx_byte, 8'h00};
            upd.phase = PH_FLEN_L;
          end
          PH_FLEN_L: begin
            upd.crc  = crc_b;
            upd.flen = {st_r.flen[15:8], rx_byte};
            if (upd.flen > cfg.max_len) begin
              fin = 1'b1;
              fst = ST_FRAMELEN;
            end else begin
              upd.stage = STG_LENGTH;
              upd.phase = PH_TYPE;
            end
          end
          PH_TYPE: begin
            upd.crc    = crc_b;
            upd.type_b = rx_byte;
            upd.stage  = STG_TYPE;
            if (tmask == cfg.ack_type || tmask == cfg.nak_type) begin
              if (st_r.flen != cfg.ack_len) begin
                fin = 1'b1;
                fst = ST_ACKLEN;
              end else begin
                upd.phase = PH_SHORT_ACK;
              end
            end else begin
              upd.phase = PH_SEQ;
            end
          end
          PH_SHORT_ACK: begin
            upd.crc   = crc_b;
            upd.ack   = rx_byte;
            upd.stage = STG_SHORT;
            upd.phase = PH_CRC_H;
          end
          PH_SEQ: begin
            upd.crc   = crc_b;
            upd.seq   = rx_byte;
            upd.stage = STG_SEQ;
            upd.phase = PH_ACK;
          end
          PH_ACK: begin
            upd.crc   = crc_b;
            upd.ack   = rx_byte;
            upd.stage = STG_ACK;
            upd.phase = PH_TLEN_H;
          end
          PH_TLEN_H: begin
            upd.crc   = crc_b;
            upd.tcnt  = {rx_byte, 8'h00};
            upd.phase = PH_TLEN_L;
          end
          PH_TLEN_L: begin
            upd.crc  = crc_b;
            upd.tcnt = {st_r.tcnt[15:8], rx_byte};
            if (tsum != {1'b0, st_r.flen}) begin
              fin = 1'b1;
              fst = ST_TEXTLEN;
            end else begin
              upd.tpos = '0;
              if (upd.tcnt == 16'h0000) begin
                upd.stage = STG_TEXT;
                upd.phase = PH_CRC_H;
              end else begin
                upd.phase = PH_TEXT;
              end
            end
          end
          PH_TEXT: begin
            upd.crc = crc_b;
            if ({1'b0, st_r.tpos} >= 17'(RX_BUFFER_BYTES)) upd.ovf = 1'b1;
            else                                           emit    = 1'b1;
            upd.tpos = pos_inc[15:0];
            if (pos_inc >= {1'b0, st_r.tcnt}) begin
              upd.stage = STG_TEXT;
              upd.phase = PH_CRC_H;
            end
          end
          PH_CRC_H: begin
            upd.crc_hi = rx_byte;
            upd.phase  = PH_CRC_L;
          end
          PH_CRC_L: begin
            fin       = 1'b1;
            upd.stage = STG_CRC;
            if ({st_r.crc_hi, rx_byte} != st_r.crc) fst = ST_CRC;
            else if (st_r.ovf)                      fst = ST_OVERFLOW;
            else                                    fst = ST_OK;
          end
          default: begin
            if (st_r.hunt > cfg.hunt_limit) begin
              fin = 1'b1;
              fst = ST_SYNC;
            end else begin
              if (st_r.hunt != HUNT_SAT) upd.hunt = st_r.hunt + 16'd1;
              upd.phase = (rx_byte == PRE_HI) ? PH_HUNT2 : PH_HUNT1;
            end
          end
        endcase
      end
    end

    st_nxt    = fin ? frame_t'('0) : upd;
    res_valid = step && (fin || emit);

    // a text byte reports the stage held before its own byte
    res.out_kind     = fin ? KIND_STATUS : KIND_TEXT;
    res.text_byte    = fin ? 8'h00 : rx_byte;
    res.text_index   = fin ? 16'h0000 : st_r.tpos;
    res.status       = fst;
    res.frame_type   = upd.type_b;
    res.seq_num      = upd.seq;
    res.ack_seq      = upd.ack;
    res.text_length  = upd.tcnt;
    res.progress     = fin ? upd.stage : st_r.stage;
    res.computed_crc = upd.crc;
  end

  a_clear_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.out_kind == KIND_STATUS |=> st_r.phase == PH_HUNT1 && st_r.crc == 16'h0000)
    else $error("frame state not cleared after status");

  a_text_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.out_kind == KIND_TEXT |->
      res.text_index < 16'(RX_BUFFER_BYTES) && res.status == ST_OK)
    else $error("text byte outside buffer");

  a_crc_stage: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == ST_CRC |-> res.progress == STG_CRC)
    else $error("crc status before crc stage");

endmodule

// ----- rtl/core/serial_frame_receiver_crc16.sv -----
// Serial frame receiver with CRC-16 (0x1021) check. One request per cycle: a received
// byte or a read timeout. A request is captured in an input register, then the frame
// state machine and the byte-wide CRC update run on it once the output register is
// free, and the result (a text byte or a frame status) lands in the output register.
// The sustained rate is one request per clock while the output side keeps taking
// results; the output register's ready sets the pace. Configuration writes take
// effect on the next cycle; the user must make them only while idle (not enforced).
module serial_frame_receiver_crc16 (
  input logic     clk,
  input logic     rst_n,
  sfr_in_if.sink  in_ch,
  sfr_out_if.source out_ch,
  sfr_cfg_if.sink cfg_ch
);
  import sfr_pkg::*;

  cfg_t      cfg;
  logic      in_v_r;
  logic      in_req_r;
  logic [7:0] in_byte_r;
  logic      out_v_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  sfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .req_type  (in_req_r),
    .rx_byte   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_req_r  <= in_ch.req_type;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_item_r <= res;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_kind     = out_item_r.out_kind;
  assign out_ch.text_byte    = out_item_r.text_byte;
  assign out_ch.text_index   = out_item_r.text_index;
  assign out_ch.status       = out_item_r.status;
  assign out_ch.frame_type   = out_item_r.frame_type;
  assign out_ch.seq_num      = out_item_r.seq_num;
  assign out_ch.ack_seq      = out_item_r.ack_seq;
  assign out_ch.text_length  = out_item_r.text_length;
  assign out_ch.progress     = out_item_r.progress;
  assign out_ch.computed_crc = out_item_r.computed_crc;

  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_byte_r) && $stable(in_req_r))
    else $error("pending request lost");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_item_r))
    else $error("waiting result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ch.ready)
    else $error("input stalled while empty");

endmodule
